// ===== rtl/core/u8dec_pkg.sv =====
// shared types, class codes and result kinds for the utf-8 stream decoder
`default_nettype none

package u8dec_pkg;

  // width of the byte position and code point counters
  localparam int COUNT_BITS = 24;
  // width of the counter fields on the result channel
  localparam int OUT_CNT_BITS = 24;
  localparam int CP_BITS = 21;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // byte classes found by the front
  localparam logic [2:0] CLS_NUL   = 3'd0;
  localparam logic [2:0] CLS_ASCII = 3'd1;
  localparam logic [2:0] CLS_CONT  = 3'd2;
  localparam logic [2:0] CLS_LEAD2 = 3'd3;
  localparam logic [2:0] CLS_LEAD3 = 3'd4;
  localparam logic [2:0] CLS_LEAD4 = 3'd5;
  localparam logic [2:0] CLS_BAD   = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // one classified byte
  typedef struct packed {
    logic [2:0] cls;
    logic [6:0] data;
  } u8dec_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/u8dec_front.sv =====
// front end: accepts raw bytes and classifies them for the back end
`default_nettype none

module u8dec_front
  import u8dec_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  output logic             push,
  output u8dec_item_t      push_item,
  input  wire logic        q_space
);

  logic [2:0] cls;

  // take a request whenever the queue has room
  assign in_ready = q_space;
  assign push     = in_valid && q_space;

  // classify the byte by its leading bits
  always_comb begin
    case (in_byte_in) inside
      8'h00:          cls = CLS_NUL;
      [8'h01:8'h7F]:  cls = CLS_ASCII;
      [8'h80:8'hBF]:  cls = CLS_CONT;
      [8'hC0:8'hDF]:  cls = CLS_LEAD2;
      [8'hE0:8'hEF]:  cls = CLS_LEAD3;
      [8'hF0:8'hF7]:  cls = CLS_LEAD4;
      default:        cls = CLS_BAD;
    endcase
  end

  assign push_item.cls  = cls;
  assign push_item.data = in_byte_in[6:0];

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_queue.sv =====
// small queue of classified bytes between front and back
`default_nettype none

module u8dec_queue
  import u8dec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire u8dec_item_t push_item,
  output logic             space,
  input  wire logic        pop,
  output u8dec_item_t      head_item,
  output logic             head_valid
);

  u8dec_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign space      = (cnt_r != QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_back.sv =====
// back end: decoder state, result building and output register
`default_nettype none

module u8dec_back
  import u8dec_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire u8dec_item_t             head_item,
  input  wire logic                    head_valid,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_kind,
  output logic [CP_BITS-1:0]           out_code_point,
  output logic [OUT_CNT_BITS-1:0]      out_count,
  output logic [OUT_CNT_BITS-1:0]      out_error_position
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [1:0]              pend_r, pend_nxt;
  logic [CP_BITS-1:0]      part_r, part_nxt;
  logic [COUNT_BITS-1:0]   pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]   pts_r, pts_nxt;
  logic                    disc_r, disc_nxt;

  logic                    out_valid_r;
  logic [1:0]              kind_r, kind_nxt;
  logic [CP_BITS-1:0]      cp_r, cp_nxt;
  logic [OUT_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [OUT_CNT_BITS-1:0] epos_r, epos_nxt;
  logic                    has_res;

  logic [COUNT_BITS-1:0]   pos_inc;
  logic [COUNT_BITS-1:0]   pts_inc;
  logic [1:0]              pend_dec;
  logic [CP_BITS-1:0]      cont_bits;
  logic [CP_BITS-1:0]      part_or;
  logic [COUNT_BITS+OUT_CNT_BITS-1:0] pos_ext;
  logic [COUNT_BITS+OUT_CNT_BITS-1:0] pts_ext;

  // take the next item when the output register is free or draining
  assign pop = head_valid && (!out_valid_r || out_ready);

  // saturating counters
  assign pos_inc = (pos_r != CNT_MAX) ? pos_r + 1'b1 : pos_r;
  assign pts_inc = (pts_r != CNT_MAX) ? pts_r + 1'b1 : pts_r;
  assign pos_ext = {{OUT_CNT_BITS{1'b0}}, pos_inc};
  assign pts_ext = {{OUT_CNT_BITS{1'b0}}, pts_r};

  // place continuation payload by remaining count
  assign pend_dec = pend_r - 1'b1;
  always_comb begin
    case (pend_dec)
      2'd0:    cont_bits = {15'b0, head_item.data[5:0]};
      2'd1:    cont_bits = {9'b0, head_item.data[5:0], 6'b0};
      2'd2:    cont_bits = {3'b0, head_item.data[5:0], 12'b0};
      default: cont_bits = '0;
    endcase
  end
  assign part_or = part_r | cont_bits;

  // decode step
  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    pos_nxt  = pos_inc;
    pts_nxt  = pts_r;
    disc_nxt = disc_r;
    has_res  = 1'b0;
    kind_nxt = KIND_POINT;
    cp_nxt   = '0;
    cnt_nxt  = '0;
    epos_nxt = '0;
    if (disc_r) begin
      if (head_item.cls == CLS_NUL) begin
        pend_nxt = '0;
        part_nxt = '0;
        pos_nxt  = '0;
        pts_nxt  = '0;
        disc_nxt = 1'b0;
      end
    end else if (pend_r == 2'd0) begin
      case (head_item.cls)
        CLS_NUL: begin
          has_res  = 1'b1;
          kind_nxt = KIND_END;
          cnt_nxt  = pts_ext[OUT_CNT_BITS-1:0];
          pend_nxt = '0;
          part_nxt = '0;
          pos_nxt  = '0;
          pts_nxt  = '0;
        end
        CLS_ASCII: begin
          has_res  = 1'b1;
          kind_nxt = KIND_POINT;
          cp_nxt   = {14'b0, head_item.data};
          cnt_nxt  = pts_ext[OUT_CNT_BITS-1:0];
          pts_nxt  = pts_inc;
        end
        CLS_LEAD2: begin
          part_nxt = {10'b0, head_item.data[4:0], 6'b0};
          pend_nxt = 2'd1;
        end
        CLS_LEAD3: begin
          part_nxt = {5'b0, head_item.data[3:0], 12'b0};
          pend_nxt = 2'd2;
        end
        CLS_LEAD4: begin
          part_nxt = {head_item.data[2:0], 18'b0};
          pend_nxt = 2'd3;
        end
        default: begin
          // stray continuation or invalid lead byte
          has_res  = 1'b1;
          kind_nxt = KIND_ERROR;
          epos_nxt = pos_ext[OUT_CNT_BITS-1:0];
          pend_nxt = '0;
          part_nxt = '0;
          disc_nxt = 1'b1;
        end
      endcase
    end else if (head_item.cls != CLS_CONT) begin
      // missing continuation byte
      has_res  = 1'b1;
      kind_nxt = KIND_ERROR;
      epos_nxt = pos_ext[OUT_CNT_BITS-1:0];
      pend_nxt = '0;
      part_nxt = '0;
      if (head_item.cls == CLS_NUL) begin
        pos_nxt = '0;
        pts_nxt = '0;
      end else begin
        disc_nxt = 1'b1;
      end
    end else begin
      pend_nxt = pend_dec;
      part_nxt = part_or;
      if (pend_dec == 2'd0) begin
        has_res  = 1'b1;
        kind_nxt = KIND_POINT;
        cp_nxt   = part_or;
        cnt_nxt  = pts_ext[OUT_CNT_BITS-1:0];
        part_nxt = '0;
        pts_nxt  = pts_inc;
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
      pos_r  <= '0;
      pts_r  <= '0;
      disc_r <= 1'b0;
    end else if (pop) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      pos_r  <= pos_nxt;
      pts_r  <= pts_nxt;
      disc_r <= disc_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= has_res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      kind_r <= kind_nxt;
      cp_r   <= cp_nxt;
      cnt_r  <= cnt_nxt;
      epos_r <= epos_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_code_point     = cp_r;
  assign out_count          = cnt_r;
  assign out_error_position = epos_r;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// top level of the utf-8 stream decoder
//
//   port group  dir  handshake            payload
//   in_         in   in_valid/in_ready    in_byte_in (8)
//   out_        out  out_valid/out_ready  out_kind (2), out_code_point (21),
//                                         out_count (24), out_error_position (24)
//
// one byte per cycle sustained while the output is not stalled; a result is
// registered in the output register after its byte has passed through a queue entry.
// rst_n clears the queue, decoder state and output valid; in_ready follows only the
// queue fill, so it rises once reset has cleared the queue, before rst_n is released.
// a stalled output holds the back end; the two-entry queue keeps in_ready up
// until it fills, and in_ready never depends on out_ready in the same cycle.
`default_nettype none

module utf8_stream_decoder
  import u8dec_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_byte_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_kind,
  output logic [CP_BITS-1:0]           out_code_point,
  output logic [OUT_CNT_BITS-1:0]      out_count,
  output logic [OUT_CNT_BITS-1:0]      out_error_position
);

  logic        push;
  u8dec_item_t push_item;
  logic        q_space;
  logic        pop;
  u8dec_item_t head_item;
  logic        head_valid;

  // byte classification
  u8dec_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .push       (push),
    .push_item  (push_item),
    .q_space    (q_space)
  );

  // decoupling queue
  u8dec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .space      (q_space),
    .pop        (pop),
    .head_item  (head_item),
    .head_valid (head_valid)
  );

  // decoding and results
  u8dec_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_item          (head_item),
    .head_valid         (head_valid),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_code_point     (out_code_point),
    .out_count          (out_count),
    .out_error_position (out_error_position)
  );

endmodule

`default_nettype wire

// ===== tb/u8dec_tb_pkg.sv =====
// decode tracker class that predicts and checks utf-8 decoder results
package u8dec_tb_pkg;
  import u8dec_pkg::*;

  // one decoded result as it leaves the block
  typedef struct packed {
    logic [1:0]              kind;
    logic [CP_BITS-1:0]      code_point;
    logic [OUT_CNT_BITS-1:0] count;
    logic [OUT_CNT_BITS-1:0] error_position;
  } decoded_t;

  class utf8_decode_tracker;
    logic [1:0]            pend_cont;
    logic [CP_BITS-1:0]    partial_cp;
    logic [COUNT_BITS-1:0] byte_pos;
    logic [COUNT_BITS-1:0] cp_count;
    bit                    skipping;
    decoded_t              decoded_q[$];
    int unsigned           n_points;
    int unsigned           n_ends;
    int unsigned           n_errors;
    int unsigned           n_mismatch;

    function new();
      clear_string();
      n_points   = 0;
      n_ends     = 0;
      n_errors   = 0;
      n_mismatch = 0;
    endfunction

    // back to the start of a fresh string
    function void clear_string();
      pend_cont  = 2'd0;
      partial_cp = '0;
      byte_pos   = '0;
      cp_count   = '0;
      skipping   = 1'b0;
    endfunction

    // advance the decoder by one accepted request and queue its result
    function void decode_byte(logic [7:0] b);
      decoded_t r;
      bit       emit;
      r    = '0;
      emit = 1'b0;
      if (byte_pos != '1) byte_pos++;

      if (skipping) begin
        // dropping bytes after an error until the terminator
        if (b == 8'h00) clear_string();
      end else if (pend_cont == 2'd0) begin
        // lead position
        if (b == 8'h00) begin
          r.kind  = KIND_END;
          r.count = OUT_CNT_BITS'(cp_count);
          emit    = 1'b1;
          clear_string();
        end else if (!b[7]) begin
          r.kind       = KIND_POINT;
          r.code_point = CP_BITS'(b);
          r.count      = OUT_CNT_BITS'(cp_count);
          emit         = 1'b1;
          if (cp_count != '1) cp_count++;
        end else if (b[7:5] == 3'b110) begin
          partial_cp = CP_BITS'({b[4:0], 6'd0});
          pend_cont  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          partial_cp = CP_BITS'({b[3:0], 12'd0});
          pend_cont  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          partial_cp = CP_BITS'({b[2:0], 18'd0});
          pend_cont  = 2'd3;
        end else begin
          // stray continuation or 11111xxx as lead
          r.kind           = KIND_ERROR;
          r.error_position = OUT_CNT_BITS'(byte_pos);
          emit             = 1'b1;
          pend_cont        = 2'd0;
          partial_cp       = '0;
          skipping         = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // continuation missing; a terminator ends the string right away
        r.kind           = KIND_ERROR;
        r.error_position = OUT_CNT_BITS'(byte_pos);
        emit             = 1'b1;
        if (b == 8'h00) begin
          clear_string();
        end else begin
          pend_cont  = 2'd0;
          partial_cp = '0;
          skipping   = 1'b1;
        end
      end else begin
        // fill in six more payload bits
        pend_cont--;
        partial_cp |= CP_BITS'(b[5:0]) << (6 * pend_cont);
        if (pend_cont == 2'd0) begin
          r.kind       = KIND_POINT;
          r.code_point = partial_cp;
          r.count      = OUT_CNT_BITS'(cp_count);
          emit         = 1'b1;
          partial_cp   = '0;
          if (cp_count != '1) cp_count++;
        end
      end

      if (emit) begin
        decoded_q.push_back(r);
        case (r.kind)
          KIND_POINT: n_points++;
          KIND_END:   n_ends++;
          default:    n_errors++;
        endcase
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void compare_result(logic [1:0] kind, logic [CP_BITS-1:0] cp,
                                 logic [OUT_CNT_BITS-1:0] cnt,
                                 logic [OUT_CNT_BITS-1:0] epos);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result with nothing predicted: kind %0d cp %h count %0d pos %0d",
                   $time, kind, cp, cnt, epos);
        return;
      end
      want = decoded_q.pop_front();
      if (kind !== want.kind || cp !== want.code_point || cnt !== want.count ||
          epos !== want.error_position) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: mismatch: got kind %0d cp %h count %0d pos %0d, %s %0d cp %h count %0d pos %0d",
                   $time, kind, cp, cnt, epos, "expected kind", want.kind,
                   want.code_point, want.count, want.error_position);
      end
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// top level bench driving the utf-8 stream decoder with byte strings
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u8dec_pkg::*;
  import u8dec_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 400;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 60;
  localparam int QUIET_FROM   = 200;
  localparam int QUIET_TO     = 300;
  localparam int N_DIRECTED   = 27;

  // hand-picked strings: extremes, every sequence length and each error path
  localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
    8'h00,                              // empty string
    8'h01, 8'h7F,                       // ascii extremes
    8'hC3, 8'hA9,                       // two-byte sequence
    8'hE2, 8'h82, 8'hAC,                // three-byte sequence
    8'hF0, 8'h9F, 8'h98, 8'h80,         // four-byte sequence
    8'hF7, 8'hBF, 8'hBF, 8'hBF,         // largest 21-bit value
    8'h00,                              // end of string
    8'h80, 8'h41, 8'h00,                // continuation as lead, then dropped
    8'hFF, 8'h00,                       // 11111xxx as lead
    8'hE2, 8'h41, 8'h00,                // missing continuation
    8'hC3, 8'h00                        // missing continuation at terminator
  };

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic [7:0]              in_byte_in = 8'h00;
  logic                    out_ready  = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic [1:0]              out_kind;
  logic [CP_BITS-1:0]      out_code_point;
  logic [OUT_CNT_BITS-1:0] out_count;
  logic [OUT_CNT_BITS-1:0] out_error_position;

  utf8_decode_tracker tracker;
  logic [7:0]         stim_q[$];
  int unsigned        sent          = 0;
  int unsigned        strings_built = 0;
  int unsigned        cycles        = 0;
  int unsigned        hold_left     = 0;
  bit                 hold_done     = 1'b0;

  always #10 clk = ~clk;

  utf8_stream_decoder u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_code_point     (out_code_point),
    .out_count          (out_count),
    .out_error_position (out_error_position)
  );

  // no idling on either side inside the quiet window
  function automatic bit quiet_window();
    return sent >= QUIET_FROM && sent < QUIET_TO;
  endfunction

  // lead byte of a sequence of the given length
  task automatic add_lead(int len);
    case (len)
      1:       stim_q.push_back({1'b0, 7'($urandom_range(1, 127))});
      2:       stim_q.push_back({3'b110, 5'($urandom)});
      3:       stim_q.push_back({4'b1110, 4'($urandom)});
      default: stim_q.push_back({5'b11110, 3'($urandom)});
    endcase
  endtask

  // complete sequence with random payload
  task automatic add_point(int len);
    add_lead(len);
    repeat (len - 1) stim_q.push_back({2'b10, 6'($urandom)});
  endtask

  // one string: mostly well formed, some broken, some plain noise
  task automatic add_string();
    int         roll;
    int         npts;
    int         len;
    logic [7:0] b;
    roll = $urandom_range(0, 99);
    npts = $urandom_range(0, 6);
    if (roll < 75) begin
      repeat (npts) add_point($urandom_range(1, 4));
    end else if (roll < 90) begin
      repeat (npts / 2) add_point($urandom_range(1, 4));
      // truncated sequence followed by a non-continuation byte or the end
      len = $urandom_range(2, 4);
      add_lead(len);
      repeat ($urandom_range(0, len - 2)) stim_q.push_back({2'b10, 6'($urandom)});
      if ($urandom_range(0, 2) != 0) begin
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        if (b != 8'h00) stim_q.push_back(b);
        repeat (npts / 2) add_point($urandom_range(1, 4));
      end
    end else begin
      repeat ($urandom_range(1, 8)) stim_q.push_back(8'($urandom));
    end
    stim_q.push_back(8'h00);
    strings_built++;
  endtask

  // offer one request, idling at random, and wait for it to be taken
  task automatic send_request(logic [7:0] b);
    while (!quiet_window() && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.decode_byte(b);
    sent++;
  endtask

  // result side: check accepted results, stall at random, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.compare_result(out_kind, out_code_point, out_count, out_error_position);
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || $urandom_range(0, 99) >= 33;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests sent", cycles, sent);
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    tracker = new();
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    while (stim_q.size() < N_DIRECTED + RANDOM_BYTES) add_string();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_q[i]) send_request(stim_q[i]);
    in_valid <= 1'b0;

    while (tracker.decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d random strings plus directed ones, %0d cycles",
             sent, strings_built, cycles);
    $display("checked %0d code points, %0d string ends, %0d encoding errors, %0d mismatches",
             tracker.n_points, tracker.n_ends, tracker.n_errors, tracker.n_mismatch);
    if (tracker.n_mismatch == 0 && tracker.decoded_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
